[hdl/i2cmts_pkg.sv]
// Package: shared constants, codes and types of the I2C master transfer sequencer.
`timescale 1ns / 1ps

package i2cmts_pkg;

    // transmit buffer geometry
    localparam int BUFFER_DEPTH = 256;
    localparam int BUF_AW       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int BYTE_W       = 8;

    // stream widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 3;

    // request opcodes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_EVENT = 2'd2;

    // sequencer phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_ADDR  = 2'd2;

    // byte engine commands
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_SEND    = 3'd2;
    localparam logic [2:0] CMD_RX_ACK  = 3'd3;
    localparam logic [2:0] CMD_RX_NACK = 3'd4;
    localparam logic [2:0] CMD_STOP    = 3'd5;

    // bus status classes
    localparam logic [2:0] ST_START   = 3'd0;
    localparam logic [2:0] ST_AW_ACK  = 3'd1;
    localparam logic [2:0] ST_AR_ACK  = 3'd2;
    localparam logic [2:0] ST_WD_ACK  = 3'd3;
    localparam logic [2:0] ST_RD_ACK  = 3'd4;
    localparam logic [2:0] ST_RD_NACK = 3'd5;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [BYTE_W-1:0] load_index;
        logic [BYTE_W-1:0] load_byte;
        logic [BYTE_W-1:0] target_address;
        logic              read_mode;
        logic [BYTE_W-1:0] transfer_length;
        logic [2:0]        bus_status;
        logic [BYTE_W-1:0] rx_byte;
        logic              write_collision;
    } t_item;

    typedef struct packed {
        logic [2:0]        bus_command;
        logic [BYTE_W-1:0] tx_byte;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_data;
        logic [BYTE_W-1:0] rx_position;
        logic              busy_res;
        logic              error_flag;
        logic              start_rejected;
    } t_result;

    // buffer write request from the sequencer
    typedef struct packed {
        logic              wen;
        logic [BUF_AW-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
    } t_buf_wr;

endpackage

[hdl/i2cmts_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module i2cmts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_wen,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[hdl/i2cmts_seq.sv]
// Sequencer core: transaction state and per-request command decision.
`timescale 1ns / 1ps

module i2cmts_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  i2cmts_pkg::t_item              i_item,
    input  logic [i2cmts_pkg::BYTE_W-1:0]  i_buf_data,   // tx_buffer[byte_index]
    output i2cmts_pkg::t_result            o_result,
    output i2cmts_pkg::t_buf_wr            o_buf_wr,
    output logic [i2cmts_pkg::BUF_AW-1:0]  o_buf_raddr   // index used by the next request
);

    logic [1:0]                      r_phase, n_phase;
    logic [i2cmts_pkg::BYTE_W-1:0]   r_addr, n_addr;
    logic                            r_reading, n_reading;
    logic [i2cmts_pkg::BYTE_W-1:0]   r_len, n_len;
    logic [i2cmts_pkg::BYTE_W-1:0]   r_idx, n_idx;
    logic                            r_failed, n_failed;
    logic                            r_active, n_active;

    logic                            load_in_range;
    logic                            idx_in_range;
    logic [i2cmts_pkg::BYTE_W-1:0]   buf_byte;

    assign load_in_range = {1'b0, i_item.load_index} < 9'(i2cmts_pkg::BUFFER_DEPTH);
    assign idx_in_range  = {1'b0, r_idx} < 9'(i2cmts_pkg::BUFFER_DEPTH);
    assign buf_byte      = idx_in_range ? i_buf_data : '0;

    always_comb begin
        logic [i2cmts_pkg::BYTE_W-1:0] idx_after;
        logic [2:0]                    expect_st;
        logic [2:0]                    cmd;
        logic [i2cmts_pkg::BYTE_W-1:0] tx;

        n_phase   = r_phase;
        n_addr    = r_addr;
        n_reading = r_reading;
        n_len     = r_len;
        n_idx     = r_idx;
        n_failed  = r_failed;
        n_active  = r_active;
        cmd       = i2cmts_pkg::CMD_NONE;
        tx        = '0;
        idx_after = r_idx;
        expect_st = i2cmts_pkg::ST_WD_ACK;

        o_result                = '0;
        o_buf_wr.wen            = 1'b0;
        o_buf_wr.waddr          = i_item.load_index[i2cmts_pkg::BUF_AW-1:0];
        o_buf_wr.wdata          = i_item.load_byte;

        if (i_en) begin
            case (i_item.opcode)
                i2cmts_pkg::OP_LOAD: begin
                    o_buf_wr.wen = load_in_range;
                end
                i2cmts_pkg::OP_START: begin
                    if (i_item.transfer_length == '0) begin
                        o_result.start_rejected = 1'b1;
                    end else begin
                        n_reading = i_item.read_mode;
                        n_addr    = i_item.read_mode ? i_item.target_address
                                                     : (i_item.target_address & 8'hFE);
                        n_len     = i_item.transfer_length;
                        n_idx     = '0;
                        n_failed  = 1'b0;
                        n_active  = 1'b1;
                        n_phase   = i2cmts_pkg::PH_IDLE;
                        cmd       = i2cmts_pkg::CMD_START;
                    end
                end
                i2cmts_pkg::OP_EVENT: begin
                    if (r_active) begin
                        case (r_phase)
                            i2cmts_pkg::PH_IDLE: begin
                                if (i_item.bus_status != i2cmts_pkg::ST_START) begin
                                    n_failed = 1'b1;
                                    n_phase  = i2cmts_pkg::PH_IDLE;
                                    n_active = 1'b0;
                                    cmd      = i2cmts_pkg::CMD_STOP;
                                end else begin
                                    n_phase = i2cmts_pkg::PH_START;
                                    tx      = r_addr;
                                    cmd     = i2cmts_pkg::CMD_SEND;
                                end
                            end
                            i2cmts_pkg::PH_START: begin
                                expect_st = r_reading ? i2cmts_pkg::ST_AR_ACK
                                                      : i2cmts_pkg::ST_AW_ACK;
                                if (i_item.bus_status != expect_st) begin
                                    n_failed = 1'b1;
                                    n_phase  = i2cmts_pkg::PH_IDLE;
                                    n_active = 1'b0;
                                    cmd      = i2cmts_pkg::CMD_STOP;
                                end else begin
                                    n_phase = i2cmts_pkg::PH_ADDR;
                                    if (!r_reading) begin
                                        n_idx = r_idx + 8'd1;
                                        if (i_item.write_collision) begin
                                            n_failed = 1'b1;
                                            n_phase  = i2cmts_pkg::PH_IDLE;
                                            n_active = 1'b0;
                                            cmd      = i2cmts_pkg::CMD_STOP;
                                        end else begin
                                            tx  = buf_byte;
                                            cmd = i2cmts_pkg::CMD_SEND;
                                        end
                                    end else begin
                                        cmd = (({1'b0, r_idx} + 9'd1) < {1'b0, r_len})
                                            ? i2cmts_pkg::CMD_RX_ACK
                                            : i2cmts_pkg::CMD_RX_NACK;
                                    end
                                end
                            end
                            default: begin
                                // data phase
                                if (r_reading && (({1'b0, r_idx} + 9'd1) == {1'b0, r_len})) begin
                                    expect_st = i2cmts_pkg::ST_RD_NACK;
                                end else begin
                                    expect_st = r_reading ? i2cmts_pkg::ST_RD_ACK
                                                          : i2cmts_pkg::ST_WD_ACK;
                                end
                                if (i_item.bus_status != expect_st) begin
                                    n_failed = 1'b1;
                                    n_phase  = i2cmts_pkg::PH_IDLE;
                                    n_active = 1'b0;
                                    cmd      = i2cmts_pkg::CMD_STOP;
                                end else begin
                                    if (r_reading) begin
                                        o_result.rx_valid    = 1'b1;
                                        o_result.rx_data     = i_item.rx_byte;
                                        o_result.rx_position = r_idx;
                                        idx_after            = r_idx + 8'd1;
                                    end
                                    n_idx = idx_after;
                                    if (idx_after == r_len) begin
                                        n_phase  = i2cmts_pkg::PH_IDLE;
                                        n_active = 1'b0;
                                        cmd      = i2cmts_pkg::CMD_STOP;
                                    end else if (r_reading) begin
                                        cmd = (({1'b0, idx_after} + 9'd1) < {1'b0, r_len})
                                            ? i2cmts_pkg::CMD_RX_ACK
                                            : i2cmts_pkg::CMD_RX_NACK;
                                    end else begin
                                        // write: next byte; only r_idx indexes the buffer here
                                        n_idx = r_idx + 8'd1;
                                        if (i_item.write_collision) begin
                                            n_failed = 1'b1;
                                            n_phase  = i2cmts_pkg::PH_IDLE;
                                            n_active = 1'b0;
                                            cmd      = i2cmts_pkg::CMD_STOP;
                                        end else begin
                                            tx  = buf_byte;
                                            cmd = i2cmts_pkg::CMD_SEND;
                                        end
                                    end
                                end
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end

        o_result.bus_command = cmd;
        o_result.tx_byte     = (cmd == i2cmts_pkg::CMD_SEND) ? tx : '0;
        o_result.busy_res    = n_active;
        o_result.error_flag  = n_failed;
    end

    assign o_buf_raddr = n_idx[i2cmts_pkg::BUF_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= i2cmts_pkg::PH_IDLE;
            r_addr    <= '0;
            r_reading <= 1'b0;
            r_len     <= '0;
            r_idx     <= '0;
            r_failed  <= 1'b0;
            r_active  <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_addr    <= n_addr;
            r_reading <= n_reading;
            r_len     <= n_len;
            r_idx     <= n_idx;
            r_failed  <= n_failed;
            r_active  <= n_active;
        end
    end

endmodule

[hdl/i2c_master_transfer_sequencer.sv]
// Top level: I2C master transfer sequencer with request and command streams.
`timescale 1ns / 1ps

// Usage
//   Slave stream (s_axis) carries requests: tuser is the opcode (load
//   transmit byte, start transaction, bus event), tdata the other fields.
//   Master stream (m_axis) carries exactly one result per request: tuser is
//   the command for the byte engine, tdata the status and received byte.
// Pipeline / throughput
//   A request accepted from s_axis lands in the input register; it is decoded
//   against the sequencer state once the result slot is free, and its result
//   is offered from the result register. One request per cycle is sustained
//   while m_axis does not stall: the transmit buffer RAM is read ahead at the
//   byte index the next request will use, with a forwarding register for a
//   load to that same index.
// Reset
//   Synchronous, active low. Clears the pipeline valid bits and the
//   sequencer (idle, no transaction, no error). Buffer contents are
//   undefined until loaded.
// Back-pressure
//   When m_axis stalls, the result register holds, the input register
//   holds once full, and s_axis tready drops; no request is lost.

module i2c_master_transfer_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] load_index, [15:8] load_byte, [23:16] target_address, [24] read_mode,
    // [32:25] transfer_length, [35:33] bus_status, [43:36] rx_byte,
    // [44] write_collision, [47:45] zero
    input  logic [i2cmts_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // [1:0] opcode
    input  logic [i2cmts_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    // master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] tx_byte, [8] rx_valid, [16:9] rx_data, [24:17] rx_position,
    // [25] busy_res, [26] error_flag, [27] start_rejected, [31:28] zero
    output logic [i2cmts_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // [2:0] bus_command
    output logic [i2cmts_pkg::M_TUSER_W-1:0] o_m_axis_tuser
);

    logic                          r_in_valid;
    i2cmts_pkg::t_item             r_in;
    i2cmts_pkg::t_item             n_in;
    logic                          r_out_valid;
    i2cmts_pkg::t_result           r_out;
    i2cmts_pkg::t_result           seq_result;

    i2cmts_pkg::t_buf_wr           buf_wr;
    logic [i2cmts_pkg::BUF_AW-1:0] buf_raddr;
    logic [i2cmts_pkg::BYTE_W-1:0] ram_rdata;
    logic [i2cmts_pkg::BYTE_W-1:0] buf_data;
    logic                          r_byp_hit;
    logic [i2cmts_pkg::BYTE_W-1:0] r_byp_data;

    logic                          out_free;
    logic                          process;
    logic                          s_fire;

    // result slot can take a new result this cycle
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign process         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    // request unpack
    always_comb begin
        n_in.opcode          = i_s_axis_tuser[1:0];
        n_in.load_index      = i_s_axis_tdata[7:0];
        n_in.load_byte       = i_s_axis_tdata[15:8];
        n_in.target_address  = i_s_axis_tdata[23:16];
        n_in.read_mode       = i_s_axis_tdata[24];
        n_in.transfer_length = i_s_axis_tdata[32:25];
        n_in.bus_status      = i_s_axis_tdata[35:33];
        n_in.rx_byte         = i_s_axis_tdata[43:36];
        n_in.write_collision = i_s_axis_tdata[44];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_fire) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in <= n_in;
        end
    end

    // transmit buffer; read address is the byte index after this cycle's request
    i2cmts_ram #(
        .WIDTH (i2cmts_pkg::BYTE_W),
        .DEPTH (i2cmts_pkg::BUFFER_DEPTH)
    ) u_tx_buf (
        .i_clk   (i_clk),
        .i_wen   (buf_wr.wen),
        .i_waddr (buf_wr.waddr),
        .i_wdata (buf_wr.wdata),
        .i_raddr (buf_raddr),
        .o_rdata (ram_rdata)
    );

    // RAM returns old data on same-address write; forward the new byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else begin
            r_byp_hit <= buf_wr.wen && (buf_wr.waddr == buf_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= buf_wr.wdata;
    end

    assign buf_data = r_byp_hit ? r_byp_data : ram_rdata;

    i2cmts_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (process),
        .i_item      (r_in),
        .i_buf_data  (buf_data),
        .o_result    (seq_result),
        .o_buf_wr    (buf_wr),
        .o_buf_raddr (buf_raddr)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out <= seq_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.bus_command;
    assign o_m_axis_tdata  = {4'b0000,
                              r_out.start_rejected,
                              r_out.error_flag,
                              r_out.busy_res,
                              r_out.rx_position,
                              r_out.rx_data,
                              r_out.rx_valid,
                              r_out.tx_byte};

endmodule
